[hdl/msxu_pkg.sv]
// Package: shared types, opcode codes and constants of the execute unit.
package msxu_pkg;

  localparam int unsigned OP_W     = 5;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TGT_W    = 10;
  localparam int unsigned IMM_HALF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_AND  = 5'd2,
    OP_OR   = 5'd3,
    OP_XOR  = 5'd4,
    OP_NOR  = 5'd5,
    OP_SLT  = 5'd6,
    OP_ADDI = 5'd7,
    OP_ANDI = 5'd8,
    OP_ORI  = 5'd9,
    OP_XORI = 5'd10,
    OP_SLTI = 5'd11,
    OP_LUI  = 5'd12,
    OP_LI   = 5'd13,
    OP_BEQ  = 5'd14,
    OP_BNE  = 5'd15,
    OP_BLTZ = 5'd16,
    OP_J    = 5'd17,
    OP_JR   = 5'd18
  } opcode_e;

  // Register file write request, driven by the execute stage.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  // Execute stage result apart from the next program counter.
  typedef struct packed {
    logic              jump_taken;
    logic              write_enable;
    logic [IDX_W-1:0]  write_index;
    logic [DATA_W-1:0] write_value;
  } exec_res_t;

  // Control-flow ops read the dest register on the second read port.
  function automatic logic reads_dest(input logic [OP_W-1:0] op);
    logic hit;
    hit = op inside {OP_BEQ, OP_BNE, OP_BLTZ, OP_J, OP_JR};
    return hit;
  endfunction

endpackage

[hdl/msxu_if.sv]
// Interfaces: instruction input channel and writeback/next-pc result channel.
interface msxu_in_if;
  import msxu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [IDX_W-1:0]         dest_index;
  logic [IDX_W-1:0]         src_a_index;
  logic [IDX_W-1:0]         src_b_index;
  logic signed [DATA_W-1:0] immediate;
  logic [TGT_W-1:0]         branch_target;

  modport source (output valid, opcode, dest_index, src_a_index, src_b_index,
                  immediate, branch_target, input ready);
  modport sink   (input valid, opcode, dest_index, src_a_index, src_b_index,
                  immediate, branch_target, output ready);
endinterface

interface msxu_out_if #(parameter int unsigned PC_WIDTH = 10);
  import msxu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PC_WIDTH-1:0]      next_pc;
  logic                     jump_taken;
  logic                     write_enable;
  logic [IDX_W-1:0]         write_index;
  logic signed [DATA_W-1:0] write_value;

  modport source (output valid, next_pc, jump_taken, write_enable, write_index,
                  write_value, input ready);
  modport sink   (input valid, next_pc, jump_taken, write_enable, write_index,
                  write_value, output ready);
endinterface

[hdl/mips_subset_execute_unit.sv]
// Top level: input register, operand read, single execute stage, result register.
// Flow: input register, then result register; operands are read at accept.
// Throughput: one item per clock unless results stall; register write, pc update
// and result capture happen at the same edge, and a same-edge write is forwarded
// to the next read. Reset: register file reads as zero at once through per-entry
// valid bits, program counter zero, both channels empty.
module mips_subset_execute_unit
  import msxu_pkg::*;
#(
  parameter int unsigned NUM_REGS = 10,
  parameter int unsigned PC_WIDTH = 10
) (
  input logic         clk_i,
  input logic         rst_ni,
  msxu_in_if.sink     in_i,
  msxu_out_if.source  out_o
);

  logic                in_vld_q;
  logic [OP_W-1:0]     op_q;
  logic [IDX_W-1:0]    rd_q;
  logic [DATA_W-1:0]   imm_q;
  logic [TGT_W-1:0]    tgt_q;
  logic [PC_WIDTH-1:0] pc_q;

  logic                out_vld_q;
  logic [PC_WIDTH-1:0] out_pc_q;
  exec_res_t           out_res_q;

  logic                accept;
  logic                fire;
  logic [IDX_W-1:0]    rd_idx  [2];
  logic [DATA_W-1:0]   rd_data [2];
  wr_req_t             wr_req;
  logic [PC_WIDTH-1:0] next_pc;
  exec_res_t           res;

  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;
  assign accept     = in_i.valid && in_i.ready;

  assign rd_idx[0] = in_i.src_a_index;
  assign rd_idx[1] = reads_dest(in_i.opcode) ? in_i.dest_index : in_i.src_b_index;

  assign wr_req.en   = fire && res.write_enable;
  assign wr_req.idx  = res.write_index;
  assign wr_req.data = res.write_value;

  msxu_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_idx_i  (rd_idx),
    .wr_i      (wr_req),
    .rd_data_o (rd_data)
  );

  msxu_exec #(
    .NUM_REGS (NUM_REGS),
    .PC_WIDTH (PC_WIDTH)
  ) u_exec (
    .op_i         (op_q),
    .dest_index_i (rd_q),
    .imm_i        (imm_q),
    .target_i     (tgt_q),
    .va_i         (rd_data[0]),
    .vx_i         (rd_data[1]),
    .pc_i         (pc_q),
    .next_pc_o    (next_pc),
    .res_o        (res)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.opcode;
      rd_q  <= in_i.dest_index;
      imm_q <= in_i.immediate;
      tgt_q <= in_i.branch_target;
    end
    if (fire) begin
      out_pc_q  <= next_pc;
      out_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        pc_q      <= next_pc;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.next_pc      = out_pc_q;
  assign out_o.jump_taken   = out_res_q.jump_taken;
  assign out_o.write_enable = out_res_q.write_enable;
  assign out_o.write_index  = out_res_q.write_index;
  assign out_o.write_value  = out_res_q.write_value;

  // Input side stalls only behind a full input stage with a blocked result.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_o.valid && !out_o.ready))
    else $error("input stalled without a blocked result");

  // Sequential flow advances the program counter by one.
  a_pc_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !res.jump_taken) |=> (pc_q == PC_WIDTH'($past(pc_q) + PC_WIDTH'(1))))
    else $error("program counter did not step by one");

  // A result without a write carries zero index and value.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.write_enable) |->
      (out_o.write_index == '0 && out_o.write_value == '0))
    else $error("non-write result carries data");

  // Writes only reach registers that exist.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> (int'(wr_req.idx) < int'(NUM_REGS)))
    else $error("write to register beyond the file");

endmodule

[hdl/msxu_regfile.sv]
// Register file: two registered read ports with write bypass, per-entry valid bits.
module msxu_regfile
  import msxu_pkg::*;
#(
  parameter int unsigned NUM_REGS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_idx_i  [2],
  input  wr_req_t           wr_i,
  output logic [DATA_W-1:0] rd_data_o [2]
);

  localparam int unsigned AW    = $clog2(NUM_REGS);
  localparam int unsigned EXT_W = (AW > IDX_W) ? AW : IDX_W;

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;

  logic [AW-1:0]     waddr;
  logic [EXT_W-1:0]  widx_ext;
  logic [AW-1:0]     raddr    [2];
  logic [EXT_W-1:0]  ridx_ext [2];
  logic              rrange   [2];

  logic [DATA_W-1:0] mem_q    [2];
  logic [DATA_W-1:0] byp_data_q;
  logic              hit_q    [2];
  logic              byp_q    [2];

  assign widx_ext = EXT_W'(wr_i.idx);
  assign waddr    = widx_ext[AW-1:0];

  for (genvar p = 0; p < 2; p++) begin : g_port
    assign ridx_ext[p]  = EXT_W'(rd_idx_i[p]);
    assign raddr[p]     = ridx_ext[p][AW-1:0];
    assign rrange[p]    = int'(rd_idx_i[p]) < int'(NUM_REGS);
    assign rd_data_o[p] = byp_q[p] ? byp_data_q :
                          (hit_q[p] ? mem_q[p] : '0);
  end

  // Writes only come with in-range indexes from the execute stage.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem_q[0]   <= mem[raddr[0]];
      mem_q[1]   <= mem[raddr[1]];
      byp_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      hit_q[0] <= 1'b0;
      hit_q[1] <= 1'b0;
      byp_q[0] <= 1'b0;
      byp_q[1] <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[waddr] <= 1'b1;
      end
      if (rd_en_i) begin
        for (int p = 0; p < 2; p++) begin
          hit_q[p] <= rrange[p] && vld_q[raddr[p]];
          // value written this cycle is not in the array yet at the read
          byp_q[p] <= wr_i.en && (wr_i.idx == rd_idx_i[p]);
        end
      end
    end
  end

endmodule

[hdl/msxu_exec.sv]
// Execute logic: ALU, compare, branch resolution and writeback select.
module msxu_exec
  import msxu_pkg::*;
#(
  parameter int unsigned NUM_REGS = 10,
  parameter int unsigned PC_WIDTH = 10
) (
  input  logic [OP_W-1:0]     op_i,
  input  logic [IDX_W-1:0]    dest_index_i,
  input  logic [DATA_W-1:0]   imm_i,
  input  logic [TGT_W-1:0]    target_i,
  input  logic [DATA_W-1:0]   va_i,
  input  logic [DATA_W-1:0]   vx_i,
  input  logic [PC_WIDTH-1:0] pc_i,
  output logic [PC_WIDTH-1:0] next_pc_o,
  output exec_res_t           res_o
);

  localparam int unsigned TW = (PC_WIDTH > TGT_W) ? PC_WIDTH : TGT_W;

  logic [TW-1:0]       tgt_ext;
  logic [PC_WIDTH-1:0] seq_pc;
  logic [DATA_W-1:0]   value;
  logic                writes;
  logic                jumped;
  logic                is_jr;
  logic                rd_ok;

  assign tgt_ext = TW'(target_i);
  assign seq_pc  = pc_i + PC_WIDTH'(1);
  assign rd_ok   = int'(dest_index_i) < int'(NUM_REGS);

  // vx_i is rt for register ops and the dest register for control flow
  always_comb begin
    value  = '0;
    writes = 1'b1;
    jumped = 1'b0;
    is_jr  = 1'b0;
    unique case (opcode_e'(op_i))
      OP_ADD:  value = va_i + vx_i;
      OP_SUB:  value = va_i - vx_i;
      OP_AND:  value = va_i & vx_i;
      OP_OR:   value = va_i | vx_i;
      OP_XOR:  value = va_i ^ vx_i;
      OP_NOR:  value = ~(va_i | vx_i);
      OP_SLT:  value = DATA_W'($signed(va_i) < $signed(vx_i));
      OP_ADDI: value = va_i + imm_i;
      OP_ANDI: value = va_i & imm_i;
      OP_ORI:  value = va_i | imm_i;
      OP_XORI: value = va_i ^ imm_i;
      OP_SLTI: value = DATA_W'($signed(va_i) < $signed(imm_i));
      OP_LUI:  value = {imm_i[IMM_HALF-1:0], {IMM_HALF{1'b0}}};
      OP_LI:   value = imm_i;
      OP_BEQ: begin
        writes = 1'b0;
        jumped = (vx_i == va_i);
      end
      OP_BNE: begin
        writes = 1'b0;
        jumped = (vx_i != va_i);
      end
      OP_BLTZ: begin
        writes = 1'b0;
        jumped = vx_i[DATA_W-1];
      end
      OP_J: begin
        writes = 1'b0;
        jumped = 1'b1;
      end
      OP_JR: begin
        writes = 1'b0;
        jumped = 1'b1;
        is_jr  = 1'b1;
      end
      default: writes = 1'b0;
    endcase
  end

  always_comb begin
    if (is_jr) begin
      next_pc_o = vx_i[PC_WIDTH-1:0];
    end else if (jumped) begin
      next_pc_o = tgt_ext[PC_WIDTH-1:0];
    end else begin
      next_pc_o = seq_pc;
    end
    res_o.jump_taken   = jumped;
    res_o.write_enable = writes && rd_ok;
    res_o.write_index  = (writes && rd_ok) ? dest_index_i : '0;
    res_o.write_value  = (writes && rd_ok) ? value : '0;
  end

endmodule

[sim/mips_subset_execute_unit_tb.sv]
// Testbench for the execute unit: predicts writeback and next pc for every accepted item.
module mips_subset_execute_unit_tb;
  import msxu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_REGS = 10;
  localparam int unsigned PC_W = 10;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 5'd19;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 5'd31;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  rd;
    logic [IDX_W-1:0]  ra;
    logic [IDX_W-1:0]  rb;
    logic [DATA_W-1:0] imm;
    logic [TGT_W-1:0]  target;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              jump_taken;
    logic              write_enable;
    logic [IDX_W-1:0]  write_index;
    logic [DATA_W-1:0] write_value;
  } wb_result_t;

  logic clk_i;
  logic rst_ni;

  msxu_in_if in_if ();
  msxu_out_if #(.PC_WIDTH(PC_W)) out_if ();

  mips_subset_execute_unit #(
    .NUM_REGS(NUM_REGS),
    .PC_WIDTH(PC_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  instr_t            instr_q[$];
  wb_result_t        wb_expect_q[$];
  logic [DATA_W-1:0] regs_model[NUM_REGS];
  logic [PC_W-1:0]   pc_model;
  int                err_cnt;
  int                tx_idle_pct;
  int                rx_idle_pct;
  bit                in_taken;
  bit                hold_req;
  int                hold_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [DATA_W-1:0] read_reg(input logic [IDX_W-1:0] i);
    return (i < NUM_REGS) ? regs_model[i] : '0;
  endfunction

  // Executes one instruction on the model state and returns its writeback.
  function automatic wb_result_t execute_instr(input instr_t ins);
    logic [DATA_W-1:0] va, vb, vd, val;
    logic [PC_W-1:0]   nxt;
    logic              jumped, writes;
    wb_result_t        r;
    va = read_reg(ins.ra);
    vb = read_reg(ins.rb);
    vd = read_reg(ins.rd);
    nxt = pc_model + PC_W'(1);
    jumped = 1'b0;
    writes = 1'b1;
    val = '0;
    case (ins.opcode)
      OP_ADD:  val = va + vb;
      OP_SUB:  val = va - vb;
      OP_AND:  val = va & vb;
      OP_OR:   val = va | vb;
      OP_XOR:  val = va ^ vb;
      OP_NOR:  val = ~(va | vb);
      OP_SLT:  val = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
      OP_ADDI: val = va + ins.imm;
      OP_ANDI: val = va & ins.imm;
      OP_ORI:  val = va | ins.imm;
      OP_XORI: val = va ^ ins.imm;
      OP_SLTI: val = ($signed(va) < $signed(ins.imm)) ? 32'd1 : 32'd0;
      OP_LUI:  val = {ins.imm[IMM_HALF-1:0], {IMM_HALF{1'b0}}};
      OP_LI:   val = ins.imm;
      OP_BEQ: begin
        writes = 1'b0;
        jumped = (vd == va);
      end
      OP_BNE: begin
        writes = 1'b0;
        jumped = (vd != va);
      end
      OP_BLTZ: begin
        writes = 1'b0;
        jumped = vd[DATA_W-1];
      end
      OP_J: begin
        writes = 1'b0;
        jumped = 1'b1;
      end
      OP_JR: begin
        writes = 1'b0;
        jumped = 1'b1;
        nxt = vd[PC_W-1:0];
      end
      default: writes = 1'b0;
    endcase
    if (jumped && ins.opcode != OP_JR) nxt = ins.target[PC_W-1:0];
    // writes past the end of the file are dropped
    if (writes && ins.rd >= NUM_REGS) writes = 1'b0;
    if (writes) regs_model[ins.rd] = val;
    else val = '0;
    pc_model = nxt;
    r.next_pc = nxt;
    r.jump_taken = jumped;
    r.write_enable = writes;
    r.write_index = writes ? ins.rd : '0;
    r.write_value = val;
    return r;
  endfunction

  function automatic instr_t mk_instr(input logic [OP_W-1:0] op, input int rd, input int ra,
                                      input int rb, input logic [DATA_W-1:0] imm,
                                      input int tgt);
    instr_t ins;
    ins.opcode = op;
    ins.rd = IDX_W'(rd);
    ins.ra = IDX_W'(ra);
    ins.rb = IDX_W'(rb);
    ins.imm = imm;
    ins.target = TGT_W'(tgt);
    return ins;
  endfunction

  // Mostly in-range register numbers, with some past the end of the file.
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(99) < 10) return IDX_W'($urandom_range((1 << IDX_W) - 1));
    return IDX_W'($urandom_range(NUM_REGS - 1));
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    if ($urandom_range(99) < 8) ins.opcode = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    else ins.opcode = OP_W'($urandom_range(OP_JR, OP_ADD));
    ins.rd = pick_index();
    ins.ra = pick_index();
    ins.rb = pick_index();
    case ($urandom_range(7))
      0, 1: ins.imm = DATA_W'($urandom_range(16) - 8);
      2: begin
        case ($urandom_range(3))
          0: ins.imm = 32'h7FFF_FFFF;
          1: ins.imm = 32'h8000_0000;
          2: ins.imm = 32'hFFFF_FFFF;
          default: ins.imm = '0;
        endcase
      end
      default: ins.imm = DATA_W'($urandom);
    endcase
    ins.target = TGT_W'($urandom);
    return ins;
  endfunction

  task automatic queue_instr(input instr_t ins);
    instr_q = {instr_q, ins};
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (err_cnt < MAX_REPORTS)
      $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic wait_drained();
    while (instr_q.size() != 0 || in_if.valid || wb_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: inputs move at the falling edge, next item only after the current one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (instr_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        instr_t cur;
        cur = instr_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.opcode <= cur.opcode;
        in_if.dest_index <= cur.rd;
        in_if.src_a_index <= cur.ra;
        in_if.src_b_index <= cur.rb;
        in_if.immediate <= cur.imm;
        in_if.branch_target <= cur.target;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Result side: random stalls plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: predict on input accept, then check any accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        instr_t     seen;
        wb_result_t pred;
        seen.opcode = in_if.opcode;
        seen.rd = in_if.dest_index;
        seen.ra = in_if.src_a_index;
        seen.rb = in_if.src_b_index;
        seen.imm = in_if.immediate;
        seen.target = in_if.branch_target;
        pred = execute_instr(seen);
        wb_expect_q = {wb_expect_q, pred};
        in_taken = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (wb_expect_q.size() == 0) begin
          report_mismatch("unexpected result next_pc", DATA_W'(out_if.next_pc), '0);
        end else begin
          wb_result_t want;
          want = wb_expect_q.pop_front();
          if (out_if.next_pc !== want.next_pc)
            report_mismatch("next_pc", DATA_W'(out_if.next_pc), DATA_W'(want.next_pc));
          if (out_if.jump_taken !== want.jump_taken)
            report_mismatch("jump_taken", DATA_W'(out_if.jump_taken),
                            DATA_W'(want.jump_taken));
          if (out_if.write_enable !== want.write_enable)
            report_mismatch("write_enable", DATA_W'(out_if.write_enable),
                            DATA_W'(want.write_enable));
          if (out_if.write_index !== want.write_index)
            report_mismatch("write_index", DATA_W'(out_if.write_index),
                            DATA_W'(want.write_index));
          if (out_if.write_value !== want.write_value)
            report_mismatch("write_value", out_if.write_value, want.write_value);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.dest_index = '0;
    in_if.src_a_index = '0;
    in_if.src_b_index = '0;
    in_if.immediate = '0;
    in_if.branch_target = '0;
    out_if.ready = 1'b0;
    err_cnt = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    in_taken = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    pc_model = '0;
    for (int i = 0; i < NUM_REGS; i++) regs_model[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every opcode, wraps, out-of-range registers, pc wrap
    queue_instr(mk_instr(OP_LI, 1, 0, 0, 32'h7FFF_FFFF, 0));
    queue_instr(mk_instr(OP_LI, 2, 0, 0, 32'h8000_0000, 0));
    queue_instr(mk_instr(OP_LI, 9, 0, 0, 32'hFFFF_FFFF, 0));
    queue_instr(mk_instr(OP_ADD, 3, 1, 1, '0, 0));
    queue_instr(mk_instr(OP_SUB, 4, 2, 1, '0, 0));
    queue_instr(mk_instr(OP_AND, 5, 1, 9, '0, 0));
    queue_instr(mk_instr(OP_OR, 6, 2, 1, '0, 0));
    queue_instr(mk_instr(OP_XOR, 7, 9, 1, '0, 0));
    queue_instr(mk_instr(OP_NOR, 8, 0, 0, '0, 0));
    queue_instr(mk_instr(OP_SLT, 0, 2, 1, '0, 0));
    queue_instr(mk_instr(OP_ADDI, 3, 1, 0, 32'd1, 0));
    queue_instr(mk_instr(OP_ANDI, 4, 9, 0, 32'h0F0F_0F0F, 0));
    queue_instr(mk_instr(OP_ORI, 5, 0, 0, 32'h8000_0000, 0));
    queue_instr(mk_instr(OP_XORI, 6, 9, 0, 32'h5555_5555, 0));
    queue_instr(mk_instr(OP_SLTI, 7, 1, 0, 32'h8000_0000, 0));
    queue_instr(mk_instr(OP_LUI, 8, 0, 0, 32'hFFFF_1234, 0));
    queue_instr(mk_instr(OP_LI, 15, 0, 0, 32'd123, 0));
    queue_instr(mk_instr(OP_ADD, 1, 15, 10, '0, 0));
    queue_instr(mk_instr(OP_BEQ, 1, 1, 0, '0, 1023));
    queue_instr(mk_instr(OP_BNE, 2, 2, 0, '0, 700));
    queue_instr(mk_instr(OP_BLTZ, 2, 0, 0, '0, 0));
    queue_instr(mk_instr(OP_BLTZ, 1, 0, 0, '0, 300));
    queue_instr(mk_instr(OP_J, 0, 0, 0, '0, 512));
    queue_instr(mk_instr(OP_JR, 9, 0, 0, '0, 0));
    queue_instr(mk_instr(OP_UNUSED_HI, 15, 15, 15, 32'hFFFF_FFFF, 1023));
    queue_instr(mk_instr(OP_UNUSED_LO, 3, 4, 5, '0, 0));
    // sender waits here until every result is back
    wait_drained();

    tx_idle_pct = 23;
    rx_idle_pct = 71;
    for (int i = 0; i < PHASE_ITEMS; i++) queue_instr(random_instr());
    wait_drained();

    tx_idle_pct = 71;
    rx_idle_pct = 23;
    for (int i = 0; i < PHASE_ITEMS; i++) queue_instr(random_instr());
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) queue_instr(random_instr());
    // long result stall while items keep coming, so the unit backs up
    hold_req = 1'b1;
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/msxu_pkg.sv
hdl/msxu_if.sv
hdl/msxu_regfile.sv
hdl/msxu_exec.sv
hdl/mips_subset_execute_unit.sv
sim/mips_subset_execute_unit_tb.sv
